@@ design/sbf_pkg.sv @@
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types and constants for the secure byte FIFO with rollback.
// ----------------------------------------------------------------------------
package sbf_pkg;

    localparam int SBF_DEPTH = 1024;
    localparam int SBF_AW    = $clog2(SBF_DEPTH);
    localparam int SBF_CW    = $clog2(SBF_DEPTH + 1);
    localparam int SBF_FW    = 11;
    localparam int SBF_BW    = 8;
    localparam int SBF_XW    = (SBF_CW > SBF_FW) ? SBF_CW : SBF_FW;

    typedef enum logic [1:0] {
        FN_PUSH    = 2'd0,
        FN_POP     = 2'd1,
        FN_UNWRITE = 2'd2,
        FN_DISCARD = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_WIPE
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [SBF_BW-1:0]  data_in;
        logic [SBF_FW-1:0]  rollback_count;
    } t_sbf_in;

    typedef struct packed {
        logic [SBF_BW-1:0]  data_out;
        logic               done_res;
        logic [SBF_FW-1:0]  fill_level;
    } t_sbf_out;

    typedef struct packed {
        logic push;
        logic pop;
        logic unwrite;
        logic discard;
        logic wipe_step;
        logic load_res;
        logic res_done;
        logic res_pop;
    } t_dp_cmd;

    typedef struct packed {
        logic cap_zero;
        logic full;
        logic empty;
        logic rb_ok;
        logic rb_zero;
        logic wipe_last;
    } t_dp_status;

endpackage

@@ design/secure_byte_fifo_with_rollback_top.sv @@
// ----------------------------------------------------------------------------
// secure_byte_fifo_with_rollback_top
// Ring-buffer byte FIFO with push, pop, unwrite and discard, wiping freed slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in) carries one operation per
//   beat; output channel (o_out_valid/i_out_ready, o_out) returns exactly one
//   result beat per operation, in order.
//   Push and refused operations: result registered at accept, posted in the
//   cycle after; a new item is taken while the result beat is taken.
//   Pop: passes through ST_POP (registered read port of the store).
//   Unwrite of N bytes zeroes the N freed slots, discard every slot of the
//   capacity; one slot is zeroed per cycle through the store write port. The
//   result beat is posted at accept; input stays stalled until the sweep ends.
//   Capacity write (i_cfg_we): empties the ring and zeroes all 1024 slots
//   with input stalled.
//   Reset: same clearing pass, capacity 0 (all operations refused).
//   Receiver stall: the result beat holds; one further item may be accepted
//   only when the pending beat is taken in the same cycle.
// ----------------------------------------------------------------------------
module secure_byte_fifo_with_rollback_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  sbf_pkg::t_sbf_in            i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output sbf_pkg::t_sbf_out           o_out,
    input  logic                        i_cfg_we,
    input  logic [sbf_pkg::SBF_FW-1:0]  i_cfg_data
);
    import sbf_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    sbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_in.func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sbf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_data     (i_in.data_in),
        .i_count    (i_in.rollback_count),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_res      (o_out)
    );

endmodule

@@ design/sbf_dp.sv @@
// ----------------------------------------------------------------------------
// sbf_dp
// Datapath: byte store, pointers, fill count, wipe sweep and result register.
// ----------------------------------------------------------------------------
module sbf_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbf_pkg::t_dp_cmd            i_cmd,
    output sbf_pkg::t_dp_status         o_status,
    input  logic [sbf_pkg::SBF_BW-1:0]  i_data,
    input  logic [sbf_pkg::SBF_FW-1:0]  i_count,
    input  logic                        i_cfg_we,
    input  logic [sbf_pkg::SBF_FW-1:0]  i_cfg_data,
    output sbf_pkg::t_sbf_out           o_res
);
    import sbf_pkg::*;

    logic [SBF_BW-1:0] r_mem [SBF_DEPTH];
    logic [SBF_BW-1:0] r_mem_q;

    logic [SBF_CW-1:0] r_cap, n_cap;
    logic [SBF_AW-1:0] r_rp, n_rp;
    logic [SBF_AW-1:0] r_wp, n_wp;
    logic [SBF_CW-1:0] r_held, n_held;
    logic [SBF_AW-1:0] r_wipe_addr, n_wipe_addr;
    logic [SBF_CW-1:0] r_wipe_left, n_wipe_left;
    logic [SBF_CW-1:0] r_wipe_lim, n_wipe_lim;

    logic [SBF_BW-1:0] r_res_data;
    logic              r_res_done;
    logic [SBF_FW-1:0] r_res_fill;

    logic              mem_we;
    logic [SBF_AW-1:0] mem_wa;
    logic [SBF_BW-1:0] mem_wd;

    logic [SBF_CW-1:0] cap_sat;
    logic [SBF_CW-1:0] cnt_c;
    logic [SBF_CW-1:0] wp_inc;
    logic [SBF_CW-1:0] rp_inc;
    logic [SBF_CW-1:0] wipe_inc;
    logic [SBF_AW-1:0] wp_back;

    assign cap_sat = (SBF_XW'(i_cfg_data) > SBF_XW'(SBF_DEPTH)) ? SBF_CW'(SBF_DEPTH)
                                                                 : SBF_CW'(i_cfg_data);
    assign cnt_c    = SBF_CW'(i_count);
    assign wp_inc   = SBF_CW'(r_wp) + SBF_CW'(1);
    assign rp_inc   = SBF_CW'(r_rp) + SBF_CW'(1);
    assign wipe_inc = SBF_CW'(r_wipe_addr) + SBF_CW'(1);
    assign wp_back  = (SBF_CW'(r_wp) >= cnt_c) ? SBF_AW'(SBF_CW'(r_wp) - cnt_c)
                                               : SBF_AW'(SBF_CW'(r_wp) + r_cap - cnt_c);

    assign o_status.cap_zero  = (r_cap == '0);
    assign o_status.full      = (r_held == r_cap);
    assign o_status.empty     = (r_held == '0);
    assign o_status.rb_ok     = (SBF_XW'(i_count) <= SBF_XW'(r_held));
    assign o_status.rb_zero   = (i_count == '0);
    assign o_status.wipe_last = (r_wipe_left == SBF_CW'(1));

    always_comb begin
        n_cap       = r_cap;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_held      = r_held;
        n_wipe_addr = r_wipe_addr;
        n_wipe_left = r_wipe_left;
        n_wipe_lim  = r_wipe_lim;
        mem_we      = 1'b0;
        mem_wa      = r_wp;
        mem_wd      = '0;
        if (i_cfg_we) begin
            n_cap       = cap_sat;
            n_rp        = '0;
            n_wp        = '0;
            n_held      = '0;
            n_wipe_addr = '0;
            n_wipe_left = SBF_CW'(SBF_DEPTH);
            n_wipe_lim  = SBF_CW'(SBF_DEPTH);
        end else begin
            if (i_cmd.push) begin
                mem_we = 1'b1;
                mem_wa = r_wp;
                mem_wd = i_data;
                n_wp   = (wp_inc == r_cap) ? '0 : SBF_AW'(wp_inc);
                n_held = r_held + SBF_CW'(1);
            end
            if (i_cmd.pop) begin
                mem_we = 1'b1;
                mem_wa = r_rp;
                n_rp   = (rp_inc == r_cap) ? '0 : SBF_AW'(rp_inc);
                n_held = r_held - SBF_CW'(1);
            end
            if (i_cmd.unwrite) begin
                n_wp        = wp_back;
                n_held      = r_held - cnt_c;
                n_wipe_addr = wp_back;
                n_wipe_left = cnt_c;
                n_wipe_lim  = r_cap;
            end
            if (i_cmd.discard) begin
                n_rp        = '0;
                n_wp        = '0;
                n_held      = '0;
                n_wipe_addr = '0;
                n_wipe_left = r_cap;
                n_wipe_lim  = r_cap;
            end
            if (i_cmd.wipe_step) begin
                mem_we      = 1'b1;
                mem_wa      = r_wipe_addr;
                n_wipe_addr = (wipe_inc == r_wipe_lim) ? '0 : SBF_AW'(wipe_inc);
                n_wipe_left = r_wipe_left - SBF_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= '0;
            r_rp        <= '0;
            r_wp        <= '0;
            r_held      <= '0;
            r_wipe_addr <= '0;
            r_wipe_left <= SBF_CW'(SBF_DEPTH);
            r_wipe_lim  <= SBF_CW'(SBF_DEPTH);
        end else begin
            r_cap       <= n_cap;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_held      <= n_held;
            r_wipe_addr <= n_wipe_addr;
            r_wipe_left <= n_wipe_left;
            r_wipe_lim  <= n_wipe_lim;
        end
    end

    // store: one write port, one registered read port (read-before-write)
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.pop) begin
            r_mem_q <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            r_res_data <= i_cmd.res_pop ? r_mem_q : '0;
            r_res_done <= i_cmd.res_done;
            r_res_fill <= SBF_FW'(n_held);
        end
    end

    assign o_res.data_out   = r_res_data;
    assign o_res.done_res   = r_res_done;
    assign o_res.fill_level = r_res_fill;

endmodule

@@ design/sbf_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbf_ctrl
// Controller: sequences operations, wipe sweeps and the result beat.
// ----------------------------------------------------------------------------
module sbf_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  sbf_pkg::t_func          i_func,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  logic                    i_cfg_we,
    input  sbf_pkg::t_dp_status     i_status,
    output sbf_pkg::t_dp_cmd        o_cmd
);
    import sbf_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WIPE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load_res = 1'b1;
                    if (!i_status.cap_zero) begin
                        case (i_func)
                            FN_PUSH: begin
                                if (!i_status.full) begin
                                    o_cmd.push     = 1'b1;
                                    o_cmd.res_done = 1'b1;
                                end
                            end
                            FN_POP: begin
                                if (!i_status.empty) begin
                                    o_cmd.pop      = 1'b1;
                                    o_cmd.load_res = 1'b0;
                                    n_state        = ST_POP;
                                end
                            end
                            FN_UNWRITE: begin
                                if (i_status.rb_ok) begin
                                    o_cmd.res_done = 1'b1;
                                    if (!i_status.rb_zero) begin
                                        o_cmd.unwrite = 1'b1;
                                        n_state       = ST_WIPE;
                                    end
                                end
                            end
                            FN_DISCARD: begin
                                o_cmd.discard  = 1'b1;
                                o_cmd.res_done = 1'b1;
                                n_state        = ST_WIPE;
                            end
                            default: begin
                                o_cmd.res_done = 1'b0;
                            end
                        endcase
                    end
                end
            end
            ST_POP: begin
                o_cmd.load_res = 1'b1;
                o_cmd.res_done = 1'b1;
                o_cmd.res_pop  = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_WIPE: begin
                o_cmd.wipe_step = 1'b1;
                if (i_status.wipe_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_WIPE;
            end
        endcase
        if (i_cfg_we) begin
            n_state = ST_WIPE;
        end
        n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.load_res;
    end

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.push, o_cmd.pop, o_cmd.unwrite, o_cmd.discard, o_cmd.wipe_step}))
        else $error("more than one datapath operation");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> (!i_status.full && !i_status.cap_zero))
        else $error("push issued on full or disabled ring");

    a_pop_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FN_POP && !i_status.cap_zero && !i_status.empty && !i_cfg_we)
        |=> (r_state == ST_POP))
        else $error("valid pop did not enter read stage");

    a_pop_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |=> r_out_valid)
        else $error("pop result beat not posted");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !accept)
        else $error("item accepted while busy");

endmodule
